### hdl/coma_pkg.sv
// Shared types and constants of the clock offset moving average unit.
// Command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package coma_pkg;

    // Field widths
    localparam int TIME_W      = 64;
    localparam int OFFSET_W    = 48;
    localparam int SUM_W       = 64;
    localparam int STREAM_W    = 3;
    localparam int ENABLE_W    = 8;
    localparam int CNT_OUT_W   = 5;

    // Packed stream widths
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 120;

    // Iterative divider: one quotient bit per step
    localparam int DIV_STEPS   = 64;
    localparam int DIV_CNT_W   = 6;

    // Request kinds carried on the input tuser bit
    localparam logic CMD_UPDATE = 1'b0;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic lookup;    // form the offset, read the oldest window entry
        logic update;    // push the offset, start the divider
        logic div_step;  // one restoring division step
        logic store;     // write the averaged offset back
        logic load_out;  // load the result register
    } coma_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic known_update;  // latched request is an update on a known stream
    } coma_status_t;

endpackage

`default_nettype wire

### hdl/coma_ctrl.sv
// Controller state machine of the clock offset moving average unit.
// Sequences capture, window update, iterative division and result load.
// Depends on coma_pkg.
`default_nettype none

module coma_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    input  coma_pkg::coma_status_t status,
    output coma_pkg::coma_cmd_t   cmd
);
    import coma_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_STORE  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_axis_tready  = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = status.known_update ? ST_UPDATE : ST_RESULT;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // Wait for the result register to be free or emptying
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

### hdl/coma_datapath.sv
// Datapath of the clock offset moving average unit: enable register,
// per-stream window state, offset window memory, divider, result register.
// Depends on coma_pkg.
`default_nettype none

module coma_datapath #(
    parameter int NUM_STREAMS   = 8,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wr_en,
    input  wire  [coma_pkg::ENABLE_W-1:0]      cfg_wr_data,
    input  wire  [0:0]                         s_axis_tuser,
    input  wire  [coma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic [0:0]                         m_axis_tuser,
    output logic [coma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  coma_pkg::coma_cmd_t                cmd,
    output coma_pkg::coma_status_t             status
);
    import coma_pkg::*;

    localparam int SIW       = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int SLW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW        = $clog2(HISTORY_DEPTH + 1);
    localparam int WIN_DEPTH = NUM_STREAMS * HISTORY_DEPTH;
    localparam int AW        = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

    // Configuration
    logic [ENABLE_W-1:0]             enable_reg;
    logic [ENABLE_W-1:0]             rise;
    logic [NUM_STREAMS+ENABLE_W-1:0] rise_ext;

    // Latched request
    logic                item_cmd_reg;
    logic [STREAM_W-1:0] item_stream_reg;
    logic [TIME_W-1:0]   local_reg;
    logic [TIME_W-1:0]   master_reg;

    // Per-stream state
    logic [SUM_W-1:0]    sum_reg    [NUM_STREAMS];
    logic [CW-1:0]       count_reg  [NUM_STREAMS];
    logic [SLW-1:0]      oldest_reg [NUM_STREAMS];
    logic [OFFSET_W-1:0] avg_reg    [NUM_STREAMS];

    // Offset window memory
    logic [OFFSET_W-1:0] win_mem [WIN_DEPTH];
    logic [OFFSET_W-1:0] rd_data_reg;
    logic [AW-1:0]       rd_addr, wr_addr;

    logic [OFFSET_W-1:0] offset_reg;
    logic [TIME_W:0]     diff;
    logic [OFFSET_W-1:0] offset_sat;

    logic [SIW-1:0]      sidx;
    logic                known;
    logic [CW-1:0]       cur_count;
    logic [SLW-1:0]      cur_oldest;
    logic [OFFSET_W-1:0] cur_avg;
    logic                full;
    logic [CW:0]         pos_sum;
    logic [SLW-1:0]      wr_pos;
    logic [SLW:0]        pos_inc;
    logic [SLW-1:0]      oldest_new;
    logic [CW-1:0]       count_new;
    logic [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]    old_ext;

    // Divider
    logic [SUM_W-1:0]    div_q_reg;
    logic [CW-1:0]       div_rem_reg;
    logic [CW-1:0]       divisor_reg;
    logic                neg_reg;
    logic [CW:0]         rem_sh;
    logic                rem_ge;
    logic [CW:0]         rem_sub;
    logic [SUM_W-1:0]    quot_signed;

    logic [TIME_W-1:0]   synced;

    // Streams whose enable bit rises get their history cleared
    assign rise     = cfg_wr_data & ~enable_reg;
    assign rise_ext = (NUM_STREAMS + ENABLE_W)'(rise);

    assign sidx       = SIW'(item_stream_reg);
    assign known      = (32'(item_stream_reg) < NUM_STREAMS) && enable_reg[item_stream_reg];
    assign cur_count  = count_reg[sidx];
    assign cur_oldest = oldest_reg[sidx];
    assign cur_avg    = avg_reg[sidx];

    assign status.known_update = known && (item_cmd_reg == CMD_UPDATE);

    // Saturate master minus local to the 48-bit signed range
    always_comb
    begin
        diff = {1'b0, master_reg} - {1'b0, local_reg};
        if (diff[TIME_W:OFFSET_W-1] == '0 || diff[TIME_W:OFFSET_W-1] == '1)
        begin
            offset_sat = diff[OFFSET_W-1:0];
        end
        else if (diff[TIME_W])
        begin
            offset_sat = {1'b1, {(OFFSET_W-1){1'b0}}};
        end
        else
        begin
            offset_sat = {1'b0, {(OFFSET_W-1){1'b1}}};
        end
    end

    // Window position and new sum
    always_comb
    begin
        full    = (cur_count == CW'(HISTORY_DEPTH));
        pos_sum = (CW+1)'(cur_oldest) + (CW+1)'(cur_count);
        if (pos_sum >= (CW+1)'(HISTORY_DEPTH))
        begin
            pos_sum = pos_sum - (CW+1)'(HISTORY_DEPTH);
        end
        pos_inc = (SLW+1)'(cur_oldest) + 1'b1;
        if (pos_inc == (SLW+1)'(HISTORY_DEPTH))
        begin
            pos_inc = '0;
        end
        if (full)
        begin
            wr_pos     = cur_oldest;
            oldest_new = pos_inc[SLW-1:0];
            count_new  = cur_count;
            old_ext    = {{(SUM_W-OFFSET_W){rd_data_reg[OFFSET_W-1]}}, rd_data_reg};
        end
        else
        begin
            wr_pos     = pos_sum[SLW-1:0];
            oldest_new = cur_oldest;
            count_new  = cur_count + 1'b1;
            old_ext    = '0;
        end
        sum_new = sum_reg[sidx] - old_ext
                + {{(SUM_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
    end

    assign rd_addr = AW'(32'(sidx) * HISTORY_DEPTH + 32'(cur_oldest));
    assign wr_addr = AW'(32'(sidx) * HISTORY_DEPTH + 32'(wr_pos));

    // Restoring division step
    always_comb
    begin
        rem_sh  = {div_rem_reg, div_q_reg[SUM_W-1]};
        rem_ge  = (rem_sh >= {1'b0, divisor_reg});
        rem_sub = rem_sh - {1'b0, divisor_reg};
        quot_signed = neg_reg ? (SUM_W'(0) - div_q_reg) : div_q_reg;
    end

    // Converted time for a known stream
    assign synced = local_reg + {{(TIME_W-OFFSET_W){cur_avg[OFFSET_W-1]}}, cur_avg};

    // Window memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            win_mem[wr_addr] <= offset_reg;
        end
        if (cmd.lookup)
        begin
            rd_data_reg <= win_mem[rd_addr];
        end
    end

    // Request, offset, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg    <= s_axis_tuser[0];
            item_stream_reg <= s_axis_tdata[2:0];
            local_reg       <= s_axis_tdata[66:3];
            master_reg      <= s_axis_tdata[130:67];
        end
        if (cmd.lookup)
        begin
            offset_reg <= offset_sat;
        end
        if (cmd.update)
        begin
            neg_reg     <= sum_new[SUM_W-1];
            div_q_reg   <= sum_new[SUM_W-1] ? (SUM_W'(0) - sum_new) : sum_new;
            div_rem_reg <= '0;
            divisor_reg <= count_new;
        end
        else if (cmd.div_step)
        begin
            div_q_reg   <= {div_q_reg[SUM_W-2:0], rem_ge};
            div_rem_reg <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        end
        if (cmd.load_out)
        begin
            if (known)
            begin
                m_axis_tdata <= {3'b000, CNT_OUT_W'(cur_count), cur_avg, synced};
                m_axis_tuser <= 1'b1;
            end
            else
            begin
                m_axis_tdata <= {{(OUT_TDATA_W-TIME_W){1'b0}}, local_reg};
                m_axis_tuser <= 1'b0;
            end
        end
    end

    // Enable register and per-stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                sum_reg[s]    <= '0;
                count_reg[s]  <= '0;
                oldest_reg[s] <= '0;
                avg_reg[s]    <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
                for (int s = 0; s < NUM_STREAMS; s++)
                begin
                    if (rise_ext[s])
                    begin
                        sum_reg[s]    <= '0;
                        count_reg[s]  <= '0;
                        oldest_reg[s] <= '0;
                        avg_reg[s]    <= '0;
                    end
                end
            end
            if (cmd.update)
            begin
                sum_reg[sidx]    <= sum_new;
                count_reg[sidx]  <= count_new;
                oldest_reg[sidx] <= oldest_new;
            end
            if (cmd.store)
            begin
                avg_reg[sidx] <= quot_signed[OFFSET_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/clock_offset_moving_average_unit.sv
// Clock offset moving average unit: estimates a clock offset per stream from
// a moving window of master-minus-local offsets and converts local times.
// An update request saturates master minus local to 48-bit signed, pushes it
// into the stream's window of the last HISTORY_DEPTH offsets and divides the
// window sum by the entry count (truncated toward zero); a convert request
// returns local time plus that average. Requests are handled one at a time.
// An update on an enabled stream steps through lookup, update, the 64-step
// restoring divider forming the average, store and result load; a convert,
// or any request on a disabled stream, goes from lookup to result load. The
// result register holds a finished result while the next request is taken in.
// Setting a stream's enable bit clears its window state on the same edge.
// Depends on coma_pkg, coma_ctrl and coma_datapath.
`default_nettype none

module clock_offset_moving_average_unit #(
    parameter int NUM_STREAMS   = 8,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // Stream enable register
    input  wire                              cfg_wr_en,
    input  wire  [coma_pkg::ENABLE_W-1:0]    cfg_wr_data,
    // Request side
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [0:0]                       s_axis_tuser,  // cmd
    input  wire  [coma_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // stream, local_time, master_time
    // Result side
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [0:0]                       m_axis_tuser,  // stream_known
    output logic [coma_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // synced_time, averaged offset,
                                                            // entries held
);
    import coma_pkg::*;

    coma_cmd_t    cmd;
    coma_status_t status;

    coma_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    coma_datapath #(
        .NUM_STREAMS   (NUM_STREAMS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .cmd          (cmd),
        .status       (status)
    );

    // One request in flight: no new request right after an accept
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while one is in flight");

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // A result load presents the result on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // The divider never runs while requests are taken
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !s_axis_tready)
        else $error("request side ready during division");

endmodule

`default_nettype wire
